// ===== src/lsbx_pkg.sv =====
// ----------------------------------------------------------------------------
// lsbx_pkg: shared types and constants of the LSB text extractor
// Channel count, character width, header geometry and the structs that
// pass between the control, lane and output modules.
// ----------------------------------------------------------------------------
package lsbx_pkg;

   localparam int INDEX_BITS    = 24;
   localparam int COUNT_BITS    = 24;
   localparam int CHAR_BITS     = 7;
   localparam int CHANNELS      = 3;
   localparam int OFFSET_BITS   = 6;
   localparam int HEADER_PIXELS = 3;
   localparam int PHASE_BITS    = 3;
   localparam int FEED_BITS     = 2;
   localparam int RUN_BITS      = 3;

   localparam logic [PHASE_BITS-1:0] LAST_PHASE = PHASE_BITS'(CHAR_BITS - 1);
   localparam logic [RUN_BITS-1:0]   NULL_RUN   = RUN_BITS'(CHAR_BITS);
   localparam logic [COUNT_BITS-1:0] COUNT_RESET = COUNT_BITS'(HEADER_PIXELS);

   // What the lanes do with the item accepted in this cycle.
   typedef struct packed {
      logic                 clear;   // first pixel of a new image
      logic [FEED_BITS-1:0] count;   // number of bits shifted in (0 to 3)
      logic                 emit;    // the single bit fed closes a character
   } feed_type;

   typedef struct packed {
      logic [CHANNELS-1:0][CHAR_BITS-1:0] chars;
      logic [CHANNELS-1:0]                valid;
      logic [CHANNELS-1:0]                ends;
      logic                               offset_error;
   } rsp_type;

endpackage

// ===== src/lsbx_ctrl.sv =====
// ----------------------------------------------------------------------------
// lsbx_ctrl: pixel index, header decode and bit phase
// Tracks the pixel position, decodes the channel enables and the start
// offset from the header pixels and tells the lanes what to shift in.
// ----------------------------------------------------------------------------
module lsbx_ctrl (
   input  logic                                                  clock,
   input  logic                                                  reset,
   input  logic                                                  accept,
   input  logic                                                  first_pixel,
   input  logic [lsbx_pkg::CHANNELS-1:0]                         lsbs,
   input  logic [lsbx_pkg::COUNT_BITS-1:0]                       pixel_count,
   output lsbx_pkg::feed_type                                    feed,
   output logic [lsbx_pkg::CHANNELS-1:0]                         lane_enable,
   output logic [lsbx_pkg::CHANNELS-1:0][lsbx_pkg::HEADER_PIXELS-1:0] lane_bits,
   output logic                                                  offset_error
);

   logic [lsbx_pkg::INDEX_BITS-1:0]  index_ff, index_in, index_eff;
   logic [lsbx_pkg::CHANNELS-1:0]    enable_ff, enable_in;
   logic [2*lsbx_pkg::CHANNELS-1:0]  header_ff, header_in;
   logic [lsbx_pkg::OFFSET_BITS-1:0] offset_ff, offset_in, offset_full;
   logic [lsbx_pkg::PHASE_BITS-1:0]  phase_ff, phase_in, phase_eff;
   logic                             halt_ff, halt_in, halt_eff;
   logic                             offset_bad;
   logic                             in_image;

   always_ff @(posedge clock) begin
      if (reset) begin
         index_ff  <= '0;
         enable_ff <= '0;
         header_ff <= '0;
         offset_ff <= '0;
         phase_ff  <= '0;
         halt_ff   <= 1'b0;
      end else begin
         index_ff  <= index_in;
         enable_ff <= enable_in;
         header_ff <= header_in;
         offset_ff <= offset_in;
         phase_ff  <= phase_in;
         halt_ff   <= halt_in;
      end
   end

   assign lane_enable = enable_ff;

   always_comb begin
      index_eff = first_pixel ? '0 : index_ff;
      phase_eff = first_pixel ? '0 : phase_ff;
      halt_eff  = first_pixel ? 1'b0 : halt_ff;

      // The offset is complete once the third header pixel is in.
      offset_full = {offset_ff[lsbx_pkg::OFFSET_BITS-1:3], lsbs[0], lsbs[1], lsbs[2]};
      offset_bad  = ({19'b0, offset_full} + 25'd3) > {1'b0, pixel_count};
      in_image    = (index_eff >= {{(lsbx_pkg::INDEX_BITS-lsbx_pkg::OFFSET_BITS){1'b0}},
                                   offset_ff})
                    && ({{(lsbx_pkg::INDEX_BITS-lsbx_pkg::COUNT_BITS){1'b0}}, pixel_count}
                        > index_eff)
                    && (index_eff != '1);

      index_in     = index_ff;
      enable_in    = enable_ff;
      header_in    = header_ff;
      offset_in    = offset_ff;
      phase_in     = phase_ff;
      halt_in      = halt_ff;
      feed         = '0;
      lane_bits    = '0;
      offset_error = 1'b0;

      if (accept) begin
         feed.clear = first_pixel;
         phase_in   = phase_eff;
         halt_in    = halt_eff;
         if (index_eff != '1) begin
            index_in = index_eff + 1'b1;
         end else begin
            index_in = index_eff;
         end

         if (!halt_eff) begin
            if (index_eff == '0) begin
               enable_in                           = lsbs;
               header_in[lsbx_pkg::CHANNELS-1:0]   = lsbs;
            end else if (index_eff == {{(lsbx_pkg::INDEX_BITS-1){1'b0}}, 1'b1}) begin
               header_in[2*lsbx_pkg::CHANNELS-1:lsbx_pkg::CHANNELS] = lsbs;
               offset_in = {lsbs[0], lsbs[1], lsbs[2], 3'b000};
            end else if (index_eff == {{(lsbx_pkg::INDEX_BITS-2){1'b0}}, 2'b10}) begin
               offset_in = offset_full;
               if (offset_bad) begin
                  halt_in      = 1'b1;
                  offset_error = 1'b1;
               end else if (offset_full < 6'd3) begin
                  // Small offsets replay the stored header bits; the phase
                  // starts at zero, so these never close a character.
                  for (int c = 0; c < lsbx_pkg::CHANNELS; c++) begin
                     case (offset_full[1:0])
                        2'd0: lane_bits[c] = {lsbs[c], header_ff[3+c], header_ff[c]};
                        2'd1: lane_bits[c] = {1'b0, lsbs[c], header_ff[3+c]};
                        default: lane_bits[c] = {2'b00, lsbs[c]};
                     endcase
                  end
                  feed.count = 2'd3 - offset_full[1:0];
                  phase_in   = {1'b0, feed.count};
               end
            end else if (in_image) begin
               for (int c = 0; c < lsbx_pkg::CHANNELS; c++) begin
                  lane_bits[c] = {2'b00, lsbs[c]};
               end
               feed.count = 2'd1;
               feed.emit  = (phase_eff == lsbx_pkg::LAST_PHASE);
               phase_in   = feed.emit ? '0 : phase_eff + 1'b1;
            end
         end
      end
   end

endmodule

// ===== src/lsbx_lane.sv =====
// ----------------------------------------------------------------------------
// lsbx_lane: one color channel of the extractor
// Shifts the low bits of its channel into a character, counts the run of
// zero bits and flags the aligned null character that ends the message.
// ----------------------------------------------------------------------------
module lsbx_lane (
   input  logic                                 clock,
   input  logic                                 reset,
   input  lsbx_pkg::feed_type                   feed,
   input  logic                                 enable,
   input  logic [lsbx_pkg::HEADER_PIXELS-1:0]   bits,
   output logic                                 char_valid,
   output logic                                 char_end,
   output logic [lsbx_pkg::CHAR_BITS-1:0]       char_value
);

   logic [lsbx_pkg::CHAR_BITS-1:0] shift_ff, shift_in, shift_next;
   logic [lsbx_pkg::RUN_BITS-1:0]  run_ff, run_in, run_next;
   logic                           done_ff, done_in;
   logic                           active;

   always_ff @(posedge clock) begin
      if (reset) begin
         shift_ff <= '0;
         run_ff   <= '0;
         done_ff  <= 1'b0;
      end else begin
         shift_ff <= shift_in;
         run_ff   <= run_in;
         done_ff  <= done_in;
      end
   end

   always_comb begin
      shift_next = shift_ff;
      run_next   = run_ff;
      for (int k = 0; k < lsbx_pkg::HEADER_PIXELS; k++) begin
         if (lsbx_pkg::FEED_BITS'(k) < feed.count) begin
            shift_next = {shift_next[lsbx_pkg::CHAR_BITS-2:0], bits[k]};
            run_next   = bits[k] ? '0 : run_next + 1'b1;
         end
      end

      active     = enable && !done_ff && (feed.count != '0) && !feed.clear;
      char_valid = active && feed.emit;
      char_end   = char_valid && (run_next == lsbx_pkg::NULL_RUN);
      char_value = char_valid ? shift_next : '0;

      shift_in = shift_ff;
      run_in   = run_ff;
      done_in  = done_ff;
      if (feed.clear) begin
         shift_in = '0;
         run_in   = '0;
         done_in  = 1'b0;
      end else if (active) begin
         shift_in = shift_next;
         run_in   = feed.emit ? '0 : run_next;
         done_in  = char_end;
      end
   end

endmodule

// ===== src/lsbx_out.sv =====
// ----------------------------------------------------------------------------
// lsbx_out: result merge and output buffer
// Merges the lane characters and the header error into one result item
// and holds it in an output register backed by a skid register.
// ----------------------------------------------------------------------------
module lsbx_out (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  lsbx_pkg::rsp_type push_data,
   input  logic              pop_stall,
   output logic              out_valid,
   output lsbx_pkg::rsp_type out_data,
   output logic              full
);

   logic              out_valid_ff, out_valid_in;
   logic              skid_valid_ff, skid_valid_in;
   lsbx_pkg::rsp_type out_ff, out_in;
   lsbx_pkg::rsp_type skid_ff, skid_in;
   logic              pop;
   logic              has_result;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign out_valid = out_valid_ff;
   assign out_data  = out_ff;
   assign full      = skid_valid_ff;

   always_comb begin
      pop           = out_valid_ff && !pop_stall;
      has_result    = push && ((push_data.valid != '0) || push_data.offset_error);
      out_valid_in  = out_valid_ff;
      skid_valid_in = skid_valid_ff;
      out_in        = out_ff;
      skid_in       = skid_ff;

      if (skid_valid_ff) begin
         if (pop) begin
            out_in        = skid_ff;
            skid_valid_in = 1'b0;
         end
      end else if (has_result) begin
         if (!out_valid_ff || pop) begin
            out_in       = push_data;
            out_valid_in = 1'b1;
         end else begin
            skid_in       = push_data;
            skid_valid_in = 1'b1;
         end
      end else if (pop) begin
         out_valid_in = 1'b0;
      end
   end

endmodule

// ===== src/lsb_stego_text_extractor.sv =====
// ----------------------------------------------------------------------------
// lsb_stego_text_extractor: hidden text recovery from pixel low bits
// Takes one RGB pixel per item and returns 7-bit characters hidden in the
// low bits of the enabled color channels, one lane per channel.
//
// Usage:
//  - req_* carries one pixel per item; req_first_pixel starts a new image.
//    An item is taken at a clock edge with req_valid high and req_stall low.
//  - rsp_* carries a result item only when a character completes on some
//    channel or the header offset is out of range; most pixels give none.
//  - csr_wr_en/csr_wr_data write pixel_count; write it while the block idles.
//  - Throughput is one pixel per clock while req_stall is low. A result
//    reaches rsp_* from the output register, or via the skid register.
//  - When rsp_stall holds, the output register keeps its item and a skid
//    register takes one more result; only then does req_stall rise, so
//    pixels that make no result keep flowing while the receiver waits.
//  - Synchronous reset clears the pixel position, header, lanes and the
//    valid flags of both output registers and sets pixel_count to 3.
// ----------------------------------------------------------------------------
module lsb_stego_text_extractor (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic                                req_first_pixel,
   input  logic [7:0]                          req_red_sample,
   input  logic [7:0]                          req_green_sample,
   input  logic [7:0]                          req_blue_sample,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [lsbx_pkg::CHAR_BITS-1:0]      rsp_red_char,
   output logic [lsbx_pkg::CHAR_BITS-1:0]      rsp_green_char,
   output logic [lsbx_pkg::CHAR_BITS-1:0]      rsp_blue_char,
   output logic                                rsp_red_valid,
   output logic                                rsp_green_valid,
   output logic                                rsp_blue_valid,
   output logic                                rsp_red_end,
   output logic                                rsp_green_end,
   output logic                                rsp_blue_end,
   output logic                                rsp_offset_error,
   input  logic                                csr_wr_en,
   input  logic [lsbx_pkg::COUNT_BITS-1:0]     csr_wr_data
);

   logic [lsbx_pkg::COUNT_BITS-1:0] pixel_count_ff, pixel_count_in;
   logic                            accept;
   logic                            full;
   logic [lsbx_pkg::CHANNELS-1:0]   lsbs;
   logic [lsbx_pkg::CHANNELS-1:0]   lane_enable;
   logic [lsbx_pkg::CHANNELS-1:0][lsbx_pkg::HEADER_PIXELS-1:0] lane_bits;
   lsbx_pkg::feed_type              feed;
   lsbx_pkg::rsp_type               merged;
   lsbx_pkg::rsp_type               result;
   logic                            offset_error;

   always_ff @(posedge clock) begin
      if (reset) begin
         pixel_count_ff <= lsbx_pkg::COUNT_RESET;
      end else begin
         pixel_count_ff <= pixel_count_in;
      end
   end

   assign pixel_count_in = csr_wr_en ? csr_wr_data : pixel_count_ff;
   assign req_stall      = full;
   assign accept         = req_valid && !full;
   assign lsbs           = {req_blue_sample[0], req_green_sample[0], req_red_sample[0]};

   lsbx_ctrl u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .accept       (accept),
      .first_pixel  (req_first_pixel),
      .lsbs         (lsbs),
      .pixel_count  (pixel_count_ff),
      .feed         (feed),
      .lane_enable  (lane_enable),
      .lane_bits    (lane_bits),
      .offset_error (offset_error)
   );

   for (genvar c = 0; c < lsbx_pkg::CHANNELS; c++) begin : g_lane
      lsbx_lane u_lane (
         .clock      (clock),
         .reset      (reset),
         .feed       (feed),
         .enable     (lane_enable[c]),
         .bits       (lane_bits[c]),
         .char_valid (merged.valid[c]),
         .char_end   (merged.ends[c]),
         .char_value (merged.chars[c])
      );
   end

   assign merged.offset_error = offset_error;

   lsbx_out u_out (
      .clock     (clock),
      .reset     (reset),
      .push      (accept),
      .push_data (merged),
      .pop_stall (rsp_stall),
      .out_valid (rsp_valid),
      .out_data  (result),
      .full      (full)
   );

   assign rsp_red_char     = result.chars[0];
   assign rsp_green_char   = result.chars[1];
   assign rsp_blue_char    = result.chars[2];
   assign rsp_red_valid    = result.valid[0];
   assign rsp_green_valid  = result.valid[1];
   assign rsp_blue_valid   = result.valid[2];
   assign rsp_red_end      = result.ends[0];
   assign rsp_green_end    = result.ends[1];
   assign rsp_blue_end     = result.ends[2];
   assign rsp_offset_error = result.offset_error;

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for lsb_stego_text_extractor
// Feeds pixel items, some typed by hand and the rest from random images with
// hidden messages, and compares every result item with a typed item or a local
// extraction model. It runs under changing pixel_count values and idle patterns.
// ----------------------------------------------------------------------------
module testbench;

   typedef enum {ROW_PREDICT, ROW_QUIET, ROW_RESULT} row_kind_type;

   typedef struct {
      row_kind_type      kind;
      bit                first;
      logic [7:0]        red;
      logic [7:0]        green;
      logic [7:0]        blue;
      lsbx_pkg::rsp_type res;
   } pixel_row_type;

   localparam int WIDE_ROW    = 8;
   localparam int HOLD_CYCLES = 300;
   localparam int PHASE_ITEMS = 75;

   logic                            clock = 1'b0;
   logic                            reset = 1'b1;
   logic                            req_valid = 1'b0;
   logic                            req_stall;
   logic                            req_first_pixel = 1'b0;
   logic [7:0]                      req_red_sample = '0;
   logic [7:0]                      req_green_sample = '0;
   logic [7:0]                      req_blue_sample = '0;
   logic                            rsp_valid;
   logic                            rsp_stall = 1'b0;
   logic [lsbx_pkg::CHAR_BITS-1:0]  rsp_red_char;
   logic [lsbx_pkg::CHAR_BITS-1:0]  rsp_green_char;
   logic [lsbx_pkg::CHAR_BITS-1:0]  rsp_blue_char;
   logic                            rsp_red_valid;
   logic                            rsp_green_valid;
   logic                            rsp_blue_valid;
   logic                            rsp_red_end;
   logic                            rsp_green_end;
   logic                            rsp_blue_end;
   logic                            rsp_offset_error;
   logic                            csr_wr_en = 1'b0;
   logic [lsbx_pkg::COUNT_BITS-1:0] csr_wr_data = '0;

   // Extraction model state.
   logic [lsbx_pkg::COUNT_BITS-1:0]  pixel_count_q = lsbx_pkg::COUNT_RESET;
   logic [lsbx_pkg::INDEX_BITS-1:0]  pix_idx;
   logic [2:0]                       chan_en;
   logic [8:0]                       hdr_bits;
   logic [lsbx_pkg::OFFSET_BITS-1:0] start_off;
   logic [lsbx_pkg::PHASE_BITS-1:0]  char_phase;
   logic [lsbx_pkg::CHAR_BITS-1:0]   shift_reg [lsbx_pkg::CHANNELS];
   logic [lsbx_pkg::RUN_BITS-1:0]    zero_len [lsbx_pkg::CHANNELS];
   bit                               lane_done [lsbx_pkg::CHANNELS];
   bit                               halted;

   lsbx_pkg::rsp_type pending_chars [$];
   int      mismatches = 0;
   int      sent_count = 0;
   int      gap_pct = 0;
   int      stall_pct = 0;
   int      hold_asked = 0;
   int      hold_seen = 0;
   int      hold_left = 0;

   lsb_stego_text_extractor dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_first_pixel  (req_first_pixel),
      .req_red_sample   (req_red_sample),
      .req_green_sample (req_green_sample),
      .req_blue_sample  (req_blue_sample),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_red_char     (rsp_red_char),
      .rsp_green_char   (rsp_green_char),
      .rsp_blue_char    (rsp_blue_char),
      .rsp_red_valid    (rsp_red_valid),
      .rsp_green_valid  (rsp_green_valid),
      .rsp_blue_valid   (rsp_blue_valid),
      .rsp_red_end      (rsp_red_end),
      .rsp_green_end    (rsp_green_end),
      .rsp_blue_end     (rsp_blue_end),
      .rsp_offset_error (rsp_offset_error),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin
      #2000000;
      $display("FAIL");
      $finish;
   end

   function automatic void clear_extractor();
      pix_idx    = '0;
      chan_en    = '0;
      hdr_bits   = '0;
      start_off  = '0;
      char_phase = '0;
      halted     = 1'b0;
      for (int c = 0; c < lsbx_pkg::CHANNELS; c++) begin
         shift_reg[c] = '0;
         zero_len[c]  = '0;
         lane_done[c] = 1'b0;
      end
   endfunction

   // Shifts one low bit into each live lane and closes characters on the
   // last bit of the seven-bit grid.
   task automatic shift_lsbs(input logic [2:0] bits, inout lsbx_pkg::rsp_type res,
                             output bit any);
      any = 1'b0;
      for (int c = 0; c < lsbx_pkg::CHANNELS; c++) begin
         if (!chan_en[c] || lane_done[c])
            continue;
         shift_reg[c] = {shift_reg[c][lsbx_pkg::CHAR_BITS-2:0], bits[c]};
         zero_len[c]  = bits[c] ? '0 : zero_len[c] + 1'b1;
         if (char_phase == lsbx_pkg::LAST_PHASE) begin
            res.chars[c] = shift_reg[c];
            res.valid[c] = 1'b1;
            if (zero_len[c] == lsbx_pkg::NULL_RUN) begin
               res.ends[c]  = 1'b1;
               lane_done[c] = 1'b1;
            end
            zero_len[c] = '0;
            any = 1'b1;
         end
      end
      char_phase = (char_phase == lsbx_pkg::LAST_PHASE) ? '0 : char_phase + 1'b1;
   endtask

   task automatic extract_pixel(input bit first, input logic [7:0] red, green, blue,
                                output bit has, output lsbx_pkg::rsp_type res);
      logic [2:0] lsbs;
      bit         any;
      res = '0;
      has = 1'b0;
      if (first)
         clear_extractor();
      lsbs = {blue[0], green[0], red[0]};
      if (!halted) begin
         if (pix_idx < lsbx_pkg::HEADER_PIXELS) begin
            hdr_bits = hdr_bits | (9'(lsbs) << (3 * pix_idx));
            if (pix_idx == 0) begin
               chan_en = lsbs;
            end else if (pix_idx == 1) begin
               start_off = {red[0], green[0], blue[0], 3'b000};
            end else begin
               start_off = start_off | {3'b000, red[0], green[0], blue[0]};
               if (int'(start_off) > int'(pixel_count_q) - 3) begin
                  halted = 1'b1;
                  res.offset_error = 1'b1;
                  has = 1'b1;
               end else begin
                  // Offsets inside the header replay the stored header bits.
                  for (int j = start_off; j < lsbx_pkg::HEADER_PIXELS; j++)
                     shift_lsbs(hdr_bits[3*j +: 3], res, any);
               end
            end
         end else if (pix_idx >= start_off && pix_idx < pixel_count_q && pix_idx != '1) begin
            shift_lsbs(lsbs, res, any);
            has = any;
         end
      end
      if (pix_idx != '1)
         pix_idx = pix_idx + 1'b1;
   endtask

   function automatic lsbx_pkg::rsp_type typed_rsp(logic [6:0] green, bit green_valid,
                                                   bit green_end, bit err);
      lsbx_pkg::rsp_type res;
      res = '0;
      res.chars[1] = green;
      res.valid[1] = green_valid;
      res.ends[1] = green_end;
      res.offset_error = err;
      return res;
   endfunction

   task automatic note_mismatch(input string msg);
      mismatches++;
      $display("mismatch at %0t: %s", $time, msg);
   endtask

   task automatic check_field(input string what, input logic [6:0] got, input logic [6:0] want);
      if (got !== want)
         note_mismatch($sformatf("%s: got %0h, expected %0h", what, got, want));
   endtask

   task automatic check_flag(input string what, input logic got, input logic want);
      if (got !== want)
         note_mismatch($sformatf("%s: got %0b, expected %0b", what, got, want));
   endtask

   // Result items are taken at the next rising edge; sample them at the falling
   // edge before it, when everything is settled.
   always @(negedge clock) begin
      lsbx_pkg::rsp_type want;
      if (!reset && rsp_valid === 1'b1 && !rsp_stall) begin
         if (pending_chars.size() == 0) begin
            note_mismatch("result item with nothing expected");
         end else begin
            want = pending_chars.pop_front();
            check_field("red_char", rsp_red_char, want.chars[0]);
            check_field("green_char", rsp_green_char, want.chars[1]);
            check_field("blue_char", rsp_blue_char, want.chars[2]);
            check_flag("red_valid", rsp_red_valid, want.valid[0]);
            check_flag("green_valid", rsp_green_valid, want.valid[1]);
            check_flag("blue_valid", rsp_blue_valid, want.valid[2]);
            check_flag("red_end", rsp_red_end, want.ends[0]);
            check_flag("green_end", rsp_green_end, want.ends[1]);
            check_flag("blue_end", rsp_blue_end, want.ends[2]);
            check_flag("offset_error", rsp_offset_error, want.offset_error);
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         hold_left = 0;
         hold_seen = hold_asked;
      end else if (hold_seen != hold_asked) begin
         hold_seen = hold_asked;
         hold_left = HOLD_CYCLES;
         rsp_stall <= 1'b1;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   task automatic offer_pixel(input bit first, input logic [7:0] red, green, blue,
                              input row_kind_type kind, input lsbx_pkg::rsp_type typed);
      bit                has;
      lsbx_pkg::rsp_type res;
      while ($urandom_range(99) < gap_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_first_pixel  <= first;
      req_red_sample   <= red;
      req_green_sample <= green;
      req_blue_sample  <= blue;
      @(negedge clock);
      while (req_stall)
         @(negedge clock);
      extract_pixel(first, red, green, blue, has, res);
      if (kind == ROW_RESULT)
         pending_chars.push_back(typed);
      else if (kind == ROW_PREDICT && has)
         pending_chars.push_back(res);
      @(posedge clock);
      sent_count++;
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      while (pending_chars.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic set_pixel_count(input logic [lsbx_pkg::COUNT_BITS-1:0] value);
      settle();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      pixel_count_q = value;
   endtask

   // One image: enable and offset header, then per-lane messages ending in a
   // null character, sometimes cut short. A few bursts are plain noise.
   task automatic send_image();
      logic [6:0]                       msg [lsbx_pkg::CHANNELS][8];
      logic [lsbx_pkg::OFFSET_BITS-1:0] off;
      logic [2:0]                       lsbs;
      logic [2:0]                       en_bits;
      int                               msg_len;
      int                               longest;
      int                               limit;
      int                               npix;
      int                               k;
      if ($urandom_range(9) == 0) begin
         repeat ($urandom_range(1, 8))
            offer_pixel($urandom_range(4) == 0, 8'($urandom), 8'($urandom), 8'($urandom),
                        ROW_PREDICT, '0);
         return;
      end
      en_bits = ($urandom_range(9) == 0) ? 3'd0 : 3'($urandom_range(1, 7));
      limit = (int'(pixel_count_q) - 3 < 63) ? int'(pixel_count_q) - 3 : 63;
      if ($urandom_range(7) == 0)
         off = 6'($urandom_range(63));
      else if ($urandom_range(1) == 0)
         off = 6'($urandom_range((limit < 9) ? limit : 9));
      else
         off = 6'($urandom_range(limit));
      longest = 0;
      for (int c = 0; c < lsbx_pkg::CHANNELS; c++) begin
         msg_len = $urandom_range(0, 4);
         for (int i = 0; i < 8; i++)
            msg[c][i] = 7'($urandom_range(1, 127));
         msg[c][msg_len] = '0;
         if (msg_len > longest)
            longest = msg_len;
      end
      npix = int'(off) + 7 * (longest + 1) + $urandom_range(0, 4);
      if ($urandom_range(4) == 0)
         npix = $urandom_range(npix, 1);
      for (int p = 0; p < npix; p++) begin
         if (p == 0) begin
            lsbs = en_bits;
         end else if (p == 1) begin
            lsbs = {off[3], off[4], off[5]};
         end else if (p == 2) begin
            lsbs = {off[0], off[1], off[2]};
         end else begin
            k = p - int'(off);
            for (int c = 0; c < lsbx_pkg::CHANNELS; c++)
               lsbs[c] = (k >= 0 && k / 7 < 8) ? msg[c][k / 7][6 - k % 7]
                                                : 1'($urandom_range(1));
         end
         offer_pixel(p == 0, {7'($urandom), lsbs[0]}, {7'($urandom), lsbs[1]},
                     {7'($urandom), lsbs[2]}, ROW_PREDICT, '0);
      end
   endtask

   initial begin
      pixel_row_type                    script [25];
      logic [lsbx_pkg::COUNT_BITS-1:0]  counts [6];
      int                               gaps [4];
      int                               stalls [4];
      bit                               paused;

      clear_extractor();
      // The first rows run under the reset pixel_count of three: a missing
      // first pixel, an offset error with the halt after it, an offset of
      // zero and a pixel past the image end. Then a green-only message with
      // an all-ones character and its null terminator at the widest count.
      script = '{
         '{ROW_PREDICT, 1'b0, 8'hFF, 8'hFF, 8'hFF, '0},
         '{ROW_PREDICT, 1'b0, 8'h00, 8'h00, 8'h00, '0},
         '{ROW_RESULT,  1'b0, 8'h00, 8'h00, 8'h01, typed_rsp(7'h00, 1'b0, 1'b0, 1'b1)},
         '{ROW_QUIET,   1'b0, 8'hFF, 8'hFF, 8'hFF, '0},
         '{ROW_PREDICT, 1'b1, 8'h01, 8'h00, 8'h01, '0},
         '{ROW_QUIET,   1'b0, 8'h00, 8'h00, 8'h00, '0},
         '{ROW_QUIET,   1'b0, 8'h00, 8'h00, 8'h00, '0},
         '{ROW_QUIET,   1'b0, 8'hFF, 8'hFF, 8'hFF, '0},
         '{ROW_PREDICT, 1'b1, 8'hFE, 8'h01, 8'h00, '0},
         '{ROW_PREDICT, 1'b0, 8'h00, 8'hFE, 8'h80, '0},
         '{ROW_PREDICT, 1'b0, 8'hFE, 8'hFF, 8'h01, '0},
         '{ROW_PREDICT, 1'b0, 8'h00, 8'hFF, 8'hFF, '0},
         '{ROW_PREDICT, 1'b0, 8'hFF, 8'h01, 8'h00, '0},
         '{ROW_PREDICT, 1'b0, 8'h55, 8'h81, 8'hAA, '0},
         '{ROW_PREDICT, 1'b0, 8'hAA, 8'h03, 8'h55, '0},
         '{ROW_PREDICT, 1'b0, 8'h80, 8'h7F, 8'h7F, '0},
         '{ROW_PREDICT, 1'b0, 8'h7F, 8'hFD, 8'h80, '0},
         '{ROW_RESULT,  1'b0, 8'hFF, 8'hFF, 8'hFF, typed_rsp(7'h7F, 1'b1, 1'b0, 1'b0)},
         '{ROW_PREDICT, 1'b0, 8'h00, 8'h00, 8'h00, '0},
         '{ROW_PREDICT, 1'b0, 8'hFF, 8'hFE, 8'hFF, '0},
         '{ROW_PREDICT, 1'b0, 8'h55, 8'hAA, 8'h55, '0},
         '{ROW_PREDICT, 1'b0, 8'hAA, 8'h54, 8'hAA, '0},
         '{ROW_PREDICT, 1'b0, 8'h01, 8'h80, 8'h01, '0},
         '{ROW_PREDICT, 1'b0, 8'hFE, 8'h02, 8'hFE, '0},
         '{ROW_RESULT,  1'b0, 8'h00, 8'h00, 8'h00, typed_rsp(7'h00, 1'b1, 1'b1, 1'b0)}
      };
      counts = '{24'd70, 24'hFFFFFF, 24'($urandom_range(20, 60)), 24'd64,
                 24'($urandom_range(3, 100)), 24'hFFFFFF};
      gaps   = '{0, 53, 0, 11};
      stalls = '{0, 0, 53, 11};

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      for (int i = 0; i < 25; i++) begin
         if (i == WIDE_ROW)
            set_pixel_count(24'hFFFFFF);
         offer_pixel(script[i].first, script[i].red, script[i].green, script[i].blue,
                     script[i].kind, script[i].res);
      end

      for (int ph = 0; ph < 6; ph++) begin
         set_pixel_count(counts[ph]);
         gap_pct = gaps[ph % 4];
         stall_pct <= stalls[ph % 4];
         // A long receiver hold while pixels keep coming fills the output
         // registers until the input stalls.
         if (ph == 2)
            hold_asked <= hold_asked + 1;
         sent_count = 0;
         paused = 1'b0;
         while (sent_count < PHASE_ITEMS) begin
            if (ph == 3 && !paused && sent_count >= PHASE_ITEMS / 2) begin
               settle();
               paused = 1'b1;
            end
            send_image();
         end
      end

      settle();
      if (mismatches == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule

// ===== sim.f =====
src/lsbx_pkg.sv
src/lsbx_ctrl.sv
src/lsbx_lane.sv
src/lsbx_out.sv
src/lsb_stego_text_extractor.sv
tb/testbench.sv
